// File: rtl/mssm_pkg.sv
`default_nettype none
package mssm_pkg;

    // Default sizes
    localparam int DefDepth     = 64;
    localparam int DefMaxStacks = 32;

    // Field widths fixed by the item format
    localparam int DataW   = 32;
    localparam int SelW    = 5;
    localparam int CountW  = 6;
    localparam int StatusW = 2;

    // Operation codes
    localparam logic CmdPush = 1'b0;
    localparam logic CmdPop  = 1'b1;

    // Result status codes
    localparam logic [StatusW-1:0] StOk        = 2'd0;
    localparam logic [StatusW-1:0] StOverflow  = 2'd1;
    localparam logic [StatusW-1:0] StUnderflow = 2'd2;
    localparam logic [StatusW-1:0] StBadStack  = 2'd3;

    // Returned when no word is popped
    localparam logic [DataW-1:0] NoValue = 32'h8000_0000;

    typedef struct packed {
        logic                    cmd;
        logic [SelW-1:0]         stack_sel;
        logic signed [DataW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [StatusW-1:0]      status;
        logic signed [DataW-1:0] pop_value;
    } t_out_item;

endpackage
`default_nettype wire

// File: rtl/multi_stack_shared_memory.sv
// Several LIFO stacks kept in one shared word memory.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): each item names a
// stack and asks for a push of its value or for a pop. Output channel
// (o_out_valid / i_out_stall / o_out_item): one result per item, in order,
// with a status and the popped word (0x80000000 when nothing is popped).
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): sets the number
// of stacks; the memory is split into equal regions of DEPTH / count words.
// A write empties every stack. Write it only while no item is in flight.
//
// Throughput: one item per cycle while the result is not stalled. A taken
// item goes through the middle stage and then the output register.
// The fill counters are updated at acceptance, so back-to-back
// items on the same stack see each other; the single memory port does one
// push write or one pop read per item, and the read data is registered.
// A stalled result is held in the output register while one more item
// waits in the middle stage; the input stalls only when both are full.
// Reset (synchronous, active low) empties all stacks and sets one stack;
// memory contents are not cleared and need no clearing pass.
`default_nettype none
module multi_stack_shared_memory
    import mssm_pkg::*;
#(
    parameter int DEPTH      = DefDepth,
    parameter int MAX_STACKS = DefMaxStacks
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CountW-1:0] i_cfg_data
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(DEPTH + 1);
    localparam int KMAX  = (MAX_STACKS < 63) ? MAX_STACKS : 63;
    localparam int NFILL = (MAX_STACKS < 32) ? MAX_STACKS : 32;
    localparam int FW    = (NFILL > 1) ? $clog2(NFILL) : 1;
    localparam int TBL   = 1 << CountW;
    localparam logic [CountW-1:0] KmaxC = CountW'(KMAX);

    // Region size per stack count, worked out at elaboration
    logic [RW-1:0] w_region_tbl [TBL];
    for (genvar k = 0; k < TBL; k++) begin : g_region
        localparam int KK = (k == 0) ? 1 : k;
        localparam int RV = (k <= KMAX) ? (DEPTH / KK) : 0;
        assign w_region_tbl[k] = RW'(RV);
    end

    // Config: stack count and region size
    logic [CountW-1:0] r_eff, n_eff;
    logic [RW-1:0]     r_region;
    logic              cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_eff = CountW'(1);
        end else if (i_cfg_data > KmaxC) begin
            n_eff = KmaxC;
        end else begin
            n_eff = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff    <= CountW'(1);
            r_region <= RW'(DEPTH);
        end else if (cfg_we) begin
            r_eff    <= n_eff;
            r_region <= w_region_tbl[n_eff];
        end
    end

    // Handshake and pipeline control
    logic r_s1_valid, r_out_valid;
    logic out_free, s1_free, in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;

    // Item decode against the current fill count
    logic [RW-1:0]   r_fill [NFILL];
    logic [FW-1:0]   fidx;
    logic [RW-1:0]   fill;
    logic            sel_ok, push_ok, pop_ok;
    logic [RW+SelW-1:0] base;
    logic [RW+SelW-1:0] addr_w;
    logic [AW-1:0]   addr;
    logic [StatusW-1:0] status;

    assign fidx    = FW'(i_in_item.stack_sel);
    assign fill    = r_fill[fidx];
    assign sel_ok  = {1'b0, i_in_item.stack_sel} < r_eff;
    assign push_ok = sel_ok && (i_in_item.cmd == CmdPush) && (fill < r_region);
    assign pop_ok  = sel_ok && (i_in_item.cmd == CmdPop) && (fill != '0);
    assign base    = (RW+SelW)'(r_region) * (RW+SelW)'(i_in_item.stack_sel);

    always_comb begin
        if (i_in_item.cmd == CmdPush) begin
            addr_w = base + (RW+SelW)'(fill);
        end else begin
            addr_w = base + (RW+SelW)'(fill) - (RW+SelW)'(1);
        end
    end
    assign addr = addr_w[AW-1:0];

    always_comb begin
        priority if (!sel_ok) begin
            status = StBadStack;
        end else if (i_in_item.cmd == CmdPush) begin
            status = push_ok ? StOk : StOverflow;
        end else begin
            status = pop_ok ? StOk : StUnderflow;
        end
    end

    // Fill counters: cleared by reset and by a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            for (int i = 0; i < NFILL; i++) begin
                r_fill[i] <= '0;
            end
        end else if (in_acc && push_ok) begin
            r_fill[fidx] <= fill + RW'(1);
        end else if (in_acc && pop_ok) begin
            r_fill[fidx] <= fill - RW'(1);
        end
    end

    // Shared word memory
    logic [DataW-1:0] mem_rdata;

    mssm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && push_ok),
        .i_re    (in_acc && pop_ok),
        .i_addr  (addr),
        .i_wdata (i_in_item.value),
        .o_rdata (mem_rdata)
    );

    // Middle stage: waits for the memory read
    logic [StatusW-1:0] r_s1_status;
    logic               r_s1_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= status;
            r_s1_pop    <= pop_ok;
        end
    end

    // Output register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out.status    <= r_s1_status;
            r_out.pop_value <= r_s1_pop ? mem_rdata : NoValue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// File: rtl/mssm_ram.sv
`default_nettype none
module mssm_ram
    import mssm_pkg::*;
#(
    parameter int DEPTH = DefDepth,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [DataW-1:0] i_wdata,
    output logic      [DataW-1:0] o_rdata
);

    logic [DataW-1:0] r_mem [DEPTH];
    logic [DataW-1:0] r_rdata;

    // Single port: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/mssm_chk.sv
`default_nettype none
module mssm_chk
    import mssm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // Any failed item returns the most negative word
    a_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != StOk) |-> o_out_item.pop_value == NoValue)
        else $error("failed item carries a popped word");

    // Nothing comes out right after reset, and the input is open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind multi_stack_shared_memory mssm_chk u_mssm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
